/* rtl/core/fir_lp_pkg.sv */
// Shared constants and coefficient function for the 19-tap low-pass FIR.
`timescale 1ns / 1ps
`default_nettype none

package fir_lp_pkg;

    localparam int TAPS       = 19;
    localparam int COEF_WIDTH = 16;
    localparam int SAMPLE_W   = 12;
    localparam int CODE_W     = 10;
    localparam int HALF_COEFS = 10;
    localparam int COEF_SHIFT = 24 - COEF_WIDTH;
    localparam int OUT_SHIFT  = COEF_WIDTH + 1;
    localparam int PROD_W     = SAMPLE_W + 1 + COEF_WIDTH;
    localparam int ACC_W      = PROD_W + $clog2(TAPS);
    localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((CODE_W + 7) / 8) * 8;

    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

    // half table, signed Q1.23
    localparam int COEF_Q23 [HALF_COEFS] = '{
        -22598, -21137, 42066, 131207, 0,
        -393545, -402836, 700292, 2469043, 3355443
    };

    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]      acc_t;

    // Q1.23 -> Q1.(COEF_WIDTH-1), round half up; symmetric tap mapping
    function automatic coef_t tap_coef(input int k);
        int     m;
        int     idx;
        longint v;
        m   = TAPS - 1 - k;
        idx = (k < m) ? k : m;
        if (idx < 0 || idx >= HALF_COEFS)
        begin
            v = 0;
        end
        else
        begin
            v = longint'(COEF_Q23[idx]);
        end
        if (COEF_SHIFT > 0)
        begin
            v = (v + (longint'(1) <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
        end
        return coef_t'(v);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fir_lp_cell.sv */
// One transposed-form FIR cell: multiply by its coefficient, add neighbor sum, register.
`timescale 1ns / 1ps
`default_nettype none

module fir_lp_cell (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic [fir_lp_pkg::SAMPLE_W-1:0]       sample,
    input  wire fir_lp_pkg::coef_t                     coef,
    input  wire fir_lp_pkg::acc_t                      sum_in,
    output fir_lp_pkg::acc_t                           sum_out
);

    logic signed [fir_lp_pkg::PROD_W-1:0] prod;
    fir_lp_pkg::acc_t                     sum_reg;
    fir_lp_pkg::acc_t                     sum_next;

    always_comb
    begin
        prod     = $signed({1'b0, sample}) * coef;
        sum_next = fir_lp_pkg::acc_t'(prod) + sum_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

`default_nettype wire

/* rtl/core/fir_lp_out.sv */
// Output stage: valid flag, rounding to converter code and saturation.
`timescale 1ns / 1ps
`default_nettype none

module fir_lp_out (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire fir_lp_pkg::acc_t                    acc,
    input  wire logic                                ready,
    output logic                                     valid,
    output logic [fir_lp_pkg::CODE_W-1:0]            code,
    output logic                                     clip
);

    logic                               valid_reg;
    logic                               valid_next;
    logic [fir_lp_pkg::ACC_W-1:0]       rnd;
    logic [fir_lp_pkg::ACC_W-1:0]       scaled;

    always_comb
    begin
        rnd    = $unsigned(acc)
               + (fir_lp_pkg::ACC_W'(1) << (fir_lp_pkg::OUT_SHIFT - 1));
        scaled = rnd >> fir_lp_pkg::OUT_SHIFT;
        if (acc < 0)
        begin
            code = '0;
            clip = 1'b1;
        end
        else if (scaled > fir_lp_pkg::ACC_W'(fir_lp_pkg::CODE_MAX))
        begin
            code = fir_lp_pkg::CODE_MAX;
            clip = 1'b1;
        end
        else
        begin
            code = scaled[fir_lp_pkg::CODE_W-1:0];
            clip = 1'b0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign valid = valid_reg;

endmodule

`default_nettype wire

/* rtl/core/fir_lowpass_19_tap_unit.sv */
// Top level of the 19-tap symmetric low-pass FIR (transposed systolic chain).
//
//  channel  dir  fields (lsb up)                      accepted when
//  s_axis   in   tdata: sample[11:0], zero pad        s_tvalid & s_tready
//  m_axis   out  tdata: dac_code[9:0]; tuser: clipped m_tvalid & m_tready
//
//  One beat per clock unless back-pressured; a result appears the cycle after its beat.
//  The cell chain advances only on an input beat; cell 0 holds the full sum
//  and doubles as the output data register.
//  Reset clears every partial sum, matching an all-zero sample history.
//  s_tready is high while the output is empty or being taken this cycle.
`timescale 1ns / 1ps
`default_nettype none

module fir_lowpass_19_tap_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [fir_lp_pkg::IN_DATA_W-1:0]     s_tdata,   // sample, zero pad
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [fir_lp_pkg::OUT_DATA_W-1:0]         m_tdata,   // dac_code, zero pad
    output logic                                      m_tuser    // clipped
);

    logic                                 accept;
    logic [fir_lp_pkg::SAMPLE_W-1:0]      sample;
    logic [fir_lp_pkg::CODE_W-1:0]        code;
    logic                                 clip;
    fir_lp_pkg::acc_t                     psum [fir_lp_pkg::TAPS+1];

    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[fir_lp_pkg::SAMPLE_W-1:0];
    assign psum[fir_lp_pkg::TAPS] = '0;

    for (genvar k = 0; k < fir_lp_pkg::TAPS; k++)
    begin : g_cell
        fir_lp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (accept),
            .sample  (sample),
            .coef    (fir_lp_pkg::tap_coef(k)),
            .sum_in  (psum[k+1]),
            .sum_out (psum[k])
        );
    end

    fir_lp_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .acc   (psum[0]),
        .ready (m_tready),
        .valid (m_tvalid),
        .code  (code),
        .clip  (clip)
    );

    assign m_tdata = fir_lp_pkg::OUT_DATA_W'(code);
    assign m_tuser = clip;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("input beat did not produce a result");

    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(psum[0]))
        else $error("filter chain moved without an input beat");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (code == '0 || code == fir_lp_pkg::CODE_MAX))
        else $error("clip flag set away from a rail");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !accept)
        else $error("input taken while result pending");

endmodule

`default_nettype wire
